// ===== rtl/core/itp_pkg.sv =====
package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int CHAR_W      = 8;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_LPAREN = 3'd5
    } t_op_code;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_FULL      = 2'd1,
        ERR_UNMATCHED = 2'd2
    } t_err_code;

    typedef enum logic [2:0] {
        CL_OTHER,
        CL_ALNUM,
        CL_LPAREN,
        CL_RPAREN,
        CL_OPER
    } t_char_class;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAIN,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // Command to the operator stack; push and pop are never both set.
    typedef struct packed {
        logic     push;
        logic     pop;
        t_op_code code;
    } t_stack_ctrl;

    localparam logic [CHAR_W-1:0] CH_ADD    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SUB    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_MUL    = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV    = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

    function automatic t_op_code op_of_char(input logic [CHAR_W-1:0] c);
        t_op_code r;
        case (c)
            CH_ADD:  r = OP_ADD;
            CH_SUB:  r = OP_SUB;
            CH_MUL:  r = OP_MUL;
            CH_DIV:  r = OP_DIV;
            default: r = OP_NONE;
        endcase
        return r;
    endfunction

    function automatic t_char_class char_class(input logic [CHAR_W-1:0] c);
        t_char_class r;
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A)) begin
            r = CL_ALNUM;
        end else if (c == CH_LPAREN) begin
            r = CL_LPAREN;
        end else if (c == CH_RPAREN) begin
            r = CL_RPAREN;
        end else if (op_of_char(c) != OP_NONE) begin
            r = CL_OPER;
        end else begin
            r = CL_OTHER;
        end
        return r;
    endfunction

    function automatic logic [1:0] op_rank(input t_op_code code);
        logic [1:0] r;
        case (code)
            OP_ADD, OP_SUB: r = 2'd1;
            OP_MUL, OP_DIV: r = 2'd2;
            default:        r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] code_char(input t_op_code code);
        logic [CHAR_W-1:0] r;
        case (code)
            OP_ADD:    r = CH_ADD;
            OP_SUB:    r = CH_SUB;
            OP_MUL:    r = CH_MUL;
            OP_DIV:    r = CH_DIV;
            OP_LPAREN: r = CH_LPAREN;
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/itp_cell.sv =====
module itp_cell (
    input  logic                  i_clk,
    input  itp_pkg::t_stack_ctrl  i_ctrl,
    input  itp_pkg::t_op_code     i_from_up,
    input  itp_pkg::t_op_code     i_from_down,
    output itp_pkg::t_op_code     o_code
);

    itp_pkg::t_op_code r_code;

    // A push moves every entry one cell deeper, a pop moves it one cell up.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_code <= i_from_up;
        end else if (i_ctrl.pop) begin
            r_code <= i_from_down;
        end
    end

    assign o_code = r_code;

endmodule

// ===== rtl/core/itp_stack.sv =====
module itp_stack (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  itp_pkg::t_stack_ctrl        i_ctrl,
    output itp_pkg::t_op_code           o_top,
    output logic [itp_pkg::CNT_W-1:0]   o_count
);

    itp_pkg::t_op_code             w_code [itp_pkg::STACK_DEPTH];
    logic [itp_pkg::CNT_W-1:0]     r_count;
    logic [itp_pkg::CNT_W-1:0]     n_count;

    for (genvar i = 0; i < itp_pkg::STACK_DEPTH; i++) begin : g_cell
        itp_pkg::t_op_code w_up;
        itp_pkg::t_op_code w_down;

        if (i == 0) begin : g_top
            assign w_up = i_ctrl.code;
        end else begin : g_mid_up
            assign w_up = w_code[i-1];
        end

        if (i == itp_pkg::STACK_DEPTH - 1) begin : g_bottom
            assign w_down = itp_pkg::OP_NONE;
        end else begin : g_mid_down
            assign w_down = w_code[i+1];
        end

        itp_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (i_ctrl),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_code      (w_code[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_ctrl.push) begin
            n_count = r_count + itp_pkg::CNT_W'(1);
        end else if (i_ctrl.pop) begin
            n_count = r_count - itp_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top   = w_code[0];
    assign o_count = r_count;

endmodule

// ===== rtl/core/infix_to_postfix_converter_top.sv =====
// Flow: a character is taken in ST_IDLE and worked in ST_MAIN, popping the stack as needed;
// a last character then passes ST_FLUSH, which pops the rest of the stack, and ST_DONE
// hands the held result to the output register. A new character is taken only in ST_IDLE,
// once the previous one is through. The cell chain makes a single stack move per cycle;
// output back-pressure can stall a state that emits or closes a word.
// Reset (synchronous, active low) empties the stack and drops any held or pending word.
module infix_to_postfix_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast,   // run_last
    output logic [3:0]  m_tuser    // [0] char_valid, [1] expr_done, [3:2] error_code
);

    itp_pkg::t_state                 r_state, n_state;
    logic [itp_pkg::CHAR_W-1:0]      r_char, n_char;
    logic                            r_last, n_last;
    itp_pkg::t_char_class            r_cls, n_cls;

    // Pending result: held back one step so its run_last can be set once known.
    logic                            r_pvalid, n_pvalid;
    logic [itp_pkg::CHAR_W-1:0]      r_pchar, n_pchar;
    logic                            r_pcv, n_pcv;
    itp_pkg::t_err_code              r_perr, n_perr;

    logic                            r_ovalid, n_ovalid;
    logic [itp_pkg::CHAR_W-1:0]      r_ochar, n_ochar;
    logic                            r_ocv, n_ocv;
    logic                            r_orun, n_orun;
    logic                            r_odone, n_odone;
    itp_pkg::t_err_code              r_oerr, n_oerr;

    itp_pkg::t_stack_ctrl            w_ctrl;
    itp_pkg::t_op_code               w_top;
    logic [itp_pkg::CNT_W-1:0]       w_count;
    logic                            w_empty;
    logic                            w_full;
    logic                            w_out_free;

    logic                            e_emit;
    logic [itp_pkg::CHAR_W-1:0]      e_char;
    logic                            e_cv;
    itp_pkg::t_err_code              e_err;
    logic                            e_close;
    logic                            e_adv;

    itp_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_top   (w_top),
        .o_count (w_count)
    );

    assign w_empty    = (w_count == '0);
    assign w_full     = (w_count == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
    assign w_out_free = !r_ovalid || m_tready;

    always_comb begin
        n_state  = r_state;
        n_char   = r_char;
        n_last   = r_last;
        n_cls    = r_cls;
        n_pvalid = r_pvalid;
        n_pchar  = r_pchar;
        n_pcv    = r_pcv;
        n_perr   = r_perr;
        n_ovalid = r_ovalid && !m_tready;
        n_ochar  = r_ochar;
        n_ocv    = r_ocv;
        n_orun   = r_orun;
        n_odone  = r_odone;
        n_oerr   = r_oerr;
        w_ctrl   = '0;
        s_tready = 1'b0;
        e_emit   = 1'b0;
        e_char   = '0;
        e_cv     = 1'b0;
        e_err    = itp_pkg::ERR_NONE;
        e_close  = 1'b0;
        e_adv    = 1'b0;

        case (r_state)
            itp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    n_char  = s_tdata;
                    n_last  = s_tlast;
                    n_cls   = itp_pkg::char_class(s_tdata);
                    n_state = itp_pkg::ST_MAIN;
                end
            end
            itp_pkg::ST_MAIN: begin
                case (r_cls)
                    itp_pkg::CL_ALNUM: begin
                        e_emit = 1'b1;
                        e_char = r_char;
                        e_cv   = 1'b1;
                        e_adv  = 1'b1;
                    end
                    itp_pkg::CL_LPAREN: begin
                        if (w_full) begin
                            e_emit = 1'b1;
                            e_err  = itp_pkg::ERR_FULL;
                        end else begin
                            w_ctrl.push = 1'b1;
                            w_ctrl.code = itp_pkg::OP_LPAREN;
                        end
                        e_adv = 1'b1;
                    end
                    itp_pkg::CL_RPAREN: begin
                        if (w_empty) begin
                            e_emit = 1'b1;
                            e_err  = itp_pkg::ERR_UNMATCHED;
                            e_adv  = 1'b1;
                        end else if (w_top == itp_pkg::OP_LPAREN) begin
                            w_ctrl.pop = 1'b1;
                            e_adv      = 1'b1;
                        end else begin
                            w_ctrl.pop = 1'b1;
                            e_emit     = 1'b1;
                            e_char     = itp_pkg::code_char(w_top);
                            e_cv       = 1'b1;
                        end
                    end
                    itp_pkg::CL_OPER: begin
                        if (!w_empty && w_top != itp_pkg::OP_LPAREN &&
                            itp_pkg::op_rank(w_top) >=
                            itp_pkg::op_rank(itp_pkg::op_of_char(r_char))) begin
                            w_ctrl.pop = 1'b1;
                            e_emit     = 1'b1;
                            e_char     = itp_pkg::code_char(w_top);
                            e_cv       = 1'b1;
                        end else if (w_full) begin
                            e_emit = 1'b1;
                            e_err  = itp_pkg::ERR_FULL;
                            e_adv  = 1'b1;
                        end else begin
                            w_ctrl.push = 1'b1;
                            w_ctrl.code = itp_pkg::op_of_char(r_char);
                            e_adv       = 1'b1;
                        end
                    end
                    default: begin
                        e_adv = 1'b1;
                    end
                endcase
                if (e_adv) begin
                    n_state = r_last ? itp_pkg::ST_FLUSH : itp_pkg::ST_DONE;
                end
            end
            itp_pkg::ST_FLUSH: begin
                if (!w_empty) begin
                    w_ctrl.pop = 1'b1;
                    if (w_top != itp_pkg::OP_LPAREN && w_top != itp_pkg::OP_NONE) begin
                        e_emit = 1'b1;
                        e_char = itp_pkg::code_char(w_top);
                        e_cv   = 1'b1;
                    end
                end else begin
                    n_state = itp_pkg::ST_DONE;
                end
            end
            itp_pkg::ST_DONE: begin
                // The held word, or an empty one at the end of an expression, closes the run.
                if (r_pvalid || r_last) begin
                    e_close = 1'b1;
                end
                if (!e_close || w_out_free) begin
                    n_state = itp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itp_pkg::ST_IDLE;
            end
        endcase

        if (e_emit) begin
            if (r_pvalid && !w_out_free) begin
                // The output is still occupied: hold everything for this cycle.
                w_ctrl  = '0;
                n_state = r_state;
            end else begin
                if (r_pvalid) begin
                    n_ovalid = 1'b1;
                    n_ochar  = r_pchar;
                    n_ocv    = r_pcv;
                    n_oerr   = r_perr;
                    n_orun   = 1'b0;
                    n_odone  = 1'b0;
                end
                n_pvalid = 1'b1;
                n_pchar  = e_char;
                n_pcv    = e_cv;
                n_perr   = e_err;
            end
        end

        if (e_close && w_out_free) begin
            n_ovalid = 1'b1;
            n_ochar  = r_pvalid ? r_pchar : '0;
            n_ocv    = r_pvalid && r_pcv;
            n_oerr   = r_pvalid ? r_perr : itp_pkg::ERR_NONE;
            n_orun   = 1'b1;
            n_odone  = r_last;
            n_pvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= itp_pkg::ST_IDLE;
            r_pvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pvalid <= n_pvalid;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_last  <= n_last;
        r_cls   <= n_cls;
        r_pchar <= n_pchar;
        r_pcv   <= n_pcv;
        r_perr  <= n_perr;
        r_ochar <= n_ochar;
        r_ocv   <= n_ocv;
        r_orun  <= n_orun;
        r_odone <= n_odone;
        r_oerr  <= n_oerr;
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_ochar;
    assign m_tlast  = r_orun;
    assign m_tuser  = {r_oerr, r_odone, r_ocv};

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH))
        else $error("operator stack count beyond its depth");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("expression end not on the last word of a run");

    a_error_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[3:2] != itp_pkg::ERR_NONE |-> !m_tuser[0])
        else $error("error word carries a character");

    a_empty_after_expr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == itp_pkg::ST_IDLE && $past(r_state == itp_pkg::ST_DONE) && $past(r_last)
        |-> w_count == '0)
        else $error("stack not empty after the end of an expression");
`endif

endmodule
